FILE: hw/rtl/stq_pkg.sv
// Package for the sorted timer expiry queue.
// Holds operation codes, result kinds, the result record and the time compare.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package stq_pkg;

    localparam int SLOTS_DEFAULT = 16;
    localparam int SLOT_ID_W = 4;
    localparam int TIME_W = 32;

    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_ABS   = 2'd1,
        OP_REL   = 2'd2,
        OP_STOP  = 2'd3
    } opcode_t;

    localparam logic KIND_ACK = 1'b0;
    localparam logic KIND_FIRED = 1'b1;
    localparam logic STATUS_OK = 1'b0;
    localparam logic STATUS_BUSY = 1'b1;

    typedef struct packed {
        logic                 kind;
        logic [SLOT_ID_W-1:0] fired_slot;
        logic                 status;
        logic [TIME_W-1:0]    current_time;
        logic                 last;
    } result_t;

    // True when a lies before b in wrap-aware order.
    function automatic logic time_before(input logic [TIME_W-1:0] a,
                                         input logic [TIME_W-1:0] b);
        logic [TIME_W-1:0] d;
        d = a - b;
        return d[TIME_W-1];
    endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/stq_ram.sv
// Simple dual-port synchronous memory with a registered read port.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module stq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int AW = $clog2(DEPTH)
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

FILE: hw/rtl/stq_ctrl.sv
// Sequencer of the timer queue: sorted insert, removal and expiry check.
// Depends on stq_pkg and stq_ram.
`timescale 1ns / 1ps
`default_nettype none

module stq_ctrl #(
    parameter int SLOTS = stq_pkg::SLOTS_DEFAULT
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            in_valid,
    output logic                                 in_ready,
    input  wire logic [1:0]                      in_opcode,
    input  wire logic [stq_pkg::SLOT_ID_W-1:0]   in_slot,
    input  wire logic [stq_pkg::TIME_W-1:0]      in_time,
    output logic                                 res_valid,
    input  wire logic                            res_ready,
    output stq_pkg::result_t                     res
);

    import stq_pkg::*;

    localparam int SW = $clog2(SLOTS);
    localparam int LW = $clog2(SLOTS + 1);

    typedef enum logic [3:0] {
        ST_IDLE, ST_INS_RD, ST_INS_ORD, ST_INS_CMP, ST_SU, ST_SU_WR,
        ST_RM_RD, ST_RM_CMP, ST_SD, ST_SD_WR, ST_HCHK, ST_H_ORD, ST_H_CMP,
        ST_EMIT_MID, ST_EMIT_LAST
    } state_t;

    state_t               state_reg;
    logic [TIME_W-1:0]    time_reg;
    logic [SLOTS-1:0]     queued_reg;
    logic [LW-1:0]        len_reg;
    logic [LW-1:0]        i_reg;
    logic [LW-1:0]        j_reg;
    logic [LW-1:0]        pos_reg;
    logic [SW-1:0]        target_reg;
    logic [TIME_W-1:0]    new_exp_reg;
    logic                 kind_reg;
    logic [SLOT_ID_W-1:0] pslot_reg;
    logic                 status_reg;

    logic                 ord_we;
    logic [SW-1:0]        ord_waddr;
    logic [SW-1:0]        ord_wdata;
    logic [SW-1:0]        ord_raddr;
    logic [SW-1:0]        ord_q;
    logic                 exp_we;
    logic [TIME_W-1:0]    exp_wdata;
    logic [SW-1:0]        exp_raddr;
    logic [TIME_W-1:0]    exp_q;

    logic                 accept;
    logic [SW-1:0]        in_idx;
    logic                 in_range;
    logic [LW-1:0]        j_dec;
    logic [LW-1:0]        j_inc;
    logic [LW-1:0]        i_inc;

    assign accept    = in_valid && in_ready;
    assign in_ready  = (state_reg == ST_IDLE);
    assign in_idx    = SW'(in_slot);
    assign in_range  = 32'(in_slot) < SLOTS;
    assign j_dec     = j_reg - LW'(1);
    assign j_inc     = j_reg + LW'(1);
    assign i_inc     = i_reg + LW'(1);
    assign exp_wdata = (opcode_t'(in_opcode) == OP_ABS) ? in_time : time_reg + in_time;
    assign exp_we    = accept && in_range && !queued_reg[in_idx]
                       && (opcode_t'(in_opcode) == OP_ABS || opcode_t'(in_opcode) == OP_REL);

    assign res_valid = (state_reg == ST_EMIT_MID) || (state_reg == ST_EMIT_LAST);
    assign res.kind = kind_reg;
    assign res.fired_slot = pslot_reg;
    assign res.status = status_reg;
    assign res.current_time = time_reg;
    assign res.last = (state_reg == ST_EMIT_LAST);

    always_comb
    begin
        ord_we    = 1'b0;
        ord_waddr = j_reg[SW-1:0];
        ord_wdata = ord_q;
        ord_raddr = '0;
        exp_raddr = ord_q;
        case (state_reg)
            ST_INS_RD: ord_raddr = i_reg[SW-1:0];
            ST_SU:
            begin
                if (j_reg > pos_reg)
                begin
                    ord_raddr = j_dec[SW-1:0];
                end
                else
                begin
                    ord_we    = 1'b1;
                    ord_waddr = pos_reg[SW-1:0];
                    ord_wdata = target_reg;
                end
            end
            ST_SU_WR: ord_we = 1'b1;
            ST_RM_RD: ord_raddr = i_reg[SW-1:0];
            ST_SD: ord_raddr = j_inc[SW-1:0];
            ST_SD_WR: ord_we = 1'b1;
            default: ;
        endcase
    end

    stq_ram #(.WIDTH(SW), .DEPTH(SLOTS)) u_order (
        .clk   (clk),
        .we    (ord_we),
        .waddr (ord_waddr),
        .wdata (ord_wdata),
        .raddr (ord_raddr),
        .rdata (ord_q)
    );

    stq_ram #(.WIDTH(TIME_W), .DEPTH(SLOTS)) u_expiry (
        .clk   (clk),
        .we    (exp_we),
        .waddr (in_idx),
        .wdata (exp_wdata),
        .raddr (exp_raddr),
        .rdata (exp_q)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            time_reg    <= '0;
            queued_reg  <= '0;
            len_reg     <= '0;
            i_reg       <= '0;
            j_reg       <= '0;
            pos_reg     <= '0;
            target_reg  <= '0;
            new_exp_reg <= '0;
            kind_reg    <= KIND_ACK;
            pslot_reg   <= '0;
            status_reg  <= STATUS_OK;
        end
        else
        begin
            case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        kind_reg    <= KIND_ACK;
                        pslot_reg   <= '0;
                        status_reg  <= STATUS_OK;
                        target_reg  <= in_idx;
                        new_exp_reg <= exp_wdata;
                        i_reg       <= '0;
                        state_reg   <= ST_HCHK;
                        if (opcode_t'(in_opcode) == OP_TICK)
                        begin
                            time_reg <= time_reg + TIME_W'(1);
                        end
                        else if (in_range)
                        begin
                            if (opcode_t'(in_opcode) == OP_STOP)
                            begin
                                if (queued_reg[in_idx])
                                begin
                                    state_reg <= ST_RM_RD;
                                end
                            end
                            else if (queued_reg[in_idx])
                            begin
                                status_reg <= STATUS_BUSY;
                            end
                            else if (len_reg == '0)
                            begin
                                pos_reg   <= '0;
                                j_reg     <= '0;
                                state_reg <= ST_SU;
                            end
                            else
                            begin
                                state_reg <= ST_INS_RD;
                            end
                        end
                    end
                end
                ST_INS_RD: state_reg <= ST_INS_ORD;
                ST_INS_ORD: state_reg <= ST_INS_CMP;
                ST_INS_CMP:
                begin
                    if (time_before(new_exp_reg, exp_q))
                    begin
                        pos_reg   <= i_reg;
                        j_reg     <= len_reg;
                        state_reg <= ST_SU;
                    end
                    else if (i_inc == len_reg)
                    begin
                        pos_reg   <= len_reg;
                        j_reg     <= len_reg;
                        state_reg <= ST_SU;
                    end
                    else
                    begin
                        i_reg     <= i_inc;
                        state_reg <= ST_INS_RD;
                    end
                end
                ST_SU:
                begin
                    if (j_reg > pos_reg)
                    begin
                        state_reg <= ST_SU_WR;
                    end
                    else
                    begin
                        len_reg                <= len_reg + LW'(1);
                        queued_reg[target_reg] <= 1'b1;
                        state_reg              <= ST_HCHK;
                    end
                end
                ST_SU_WR:
                begin
                    j_reg     <= j_dec;
                    state_reg <= ST_SU;
                end
                ST_RM_RD: state_reg <= ST_RM_CMP;
                ST_RM_CMP:
                begin
                    if (ord_q == target_reg)
                    begin
                        j_reg     <= i_reg;
                        state_reg <= ST_SD;
                    end
                    else
                    begin
                        i_reg     <= i_inc;
                        state_reg <= ST_RM_RD;
                    end
                end
                ST_SD:
                begin
                    if (j_inc < len_reg)
                    begin
                        state_reg <= ST_SD_WR;
                    end
                    else
                    begin
                        len_reg                <= len_reg - LW'(1);
                        queued_reg[target_reg] <= 1'b0;
                        state_reg              <= ST_HCHK;
                    end
                end
                ST_SD_WR:
                begin
                    j_reg     <= j_inc;
                    state_reg <= ST_SD;
                end
                ST_HCHK:
                begin
                    state_reg <= (len_reg == '0) ? ST_EMIT_LAST : ST_H_ORD;
                end
                ST_H_ORD:
                begin
                    target_reg <= ord_q;
                    state_reg  <= ST_H_CMP;
                end
                ST_H_CMP:
                begin
                    if (time_before(time_reg, exp_q))
                    begin
                        state_reg <= ST_EMIT_LAST;
                    end
                    else
                    begin
                        state_reg <= ST_EMIT_MID;
                    end
                end
                ST_EMIT_MID:
                begin
                    if (res_ready)
                    begin
                        kind_reg   <= KIND_FIRED;
                        pslot_reg  <= SLOT_ID_W'(target_reg);
                        status_reg <= STATUS_OK;
                        j_reg      <= '0;
                        state_reg  <= ST_SD;
                    end
                end
                ST_EMIT_LAST:
                begin
                    if (res_ready)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/sorted_timer_expiry_queue_core.sv
// Top level of the sorted timer expiry queue: stream ports and output register.
// Depends on stq_pkg and stq_ctrl.
//
// Usage: each input item on the s_ side carries an operation in s_tuser (tick,
// start at absolute time, start relative to now, stop) with a slot and a time
// value in s_tdata. Every item yields one acknowledgement item with a status and
// the current time, followed by one fired item for each timer whose expiry has
// been reached, in expiry order; m_tlast marks the final item of that group.
// Timers live in a sorted order list and an expiry table, both synchronous
// memories with a registered read port, walked one entry at a time.
// An item holds the sequencer from its accepting cycle on. A start reads the order
// list and the expiry table entry by entry until it finds a later expiry, shifts
// the later entries up one place and writes the new entry; a stop reads up to and
// including its slot, shifts the later entries down and closes the gap. The head
// check, skipped on an empty queue, reads the head's expiry and compares it with
// the current time; a fired timer is removed by shifting the remaining entries
// down before the next head check. Each result item passes through the output
// register before it shows on m_tvalid.
// s_tready is high only while the block is idle. A stalled receiver holds the
// result in the output register and the sequencer waits behind it. Reset clears
// the time counter and empties the queue; no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none

module sorted_timer_expiry_queue_core #(
    parameter int SLOTS = stq_pkg::SLOTS_DEFAULT
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [39:0] s_tdata,   // slot_id[3:0], time_value[35:4], zero pad
    input  wire logic [1:0]  s_tuser,   // opcode[1:0]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [39:0] m_tdata,   // fired_slot[3:0], status[4], current_time[36:5]
    output logic             m_tuser,   // kind[0]
    output logic             m_tlast
);

    import stq_pkg::*;

    logic    res_valid;
    logic    res_ready;
    result_t res;
    result_t out_reg;
    logic    out_valid_reg;

    assign res_ready = !out_valid_reg || m_tready;

    stq_ctrl #(.SLOTS(SLOTS)) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_opcode (s_tuser),
        .in_slot   (s_tdata[3:0]),
        .in_time   (s_tdata[35:4]),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            out_reg       <= '0;
        end
        else if (res_ready)
        begin
            out_valid_reg <= res_valid;
            if (res_valid)
            begin
                out_reg <= res;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_reg.kind;
    assign m_tlast  = out_reg.last;
    assign m_tdata  = {3'b000, out_reg.current_time, out_reg.status, out_reg.fired_slot};

endmodule

`default_nettype wire

FILE: test/stq_checker.sv
// Checker for the sorted timer expiry queue: watches both stream channels,
// keeps its own timer list model and compares every result item field by field.
// Depends on stq_pkg.
`timescale 1ns / 1ps

module stq_checker (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    input  wire logic        s_tready,
    input  wire logic [39:0] s_tdata,
    input  wire logic [1:0]  s_tuser,
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    input  wire logic [39:0] m_tdata,
    input  wire logic        m_tuser,
    input  wire logic        m_tlast,
    output int               errors,
    output int               pending,
    output int               fired_seen,
    output int               refused_seen
);
    import stq_pkg::*;

    logic [31:0] now_q;
    logic [31:0] expiry_q [16];
    logic        queued_q [16];
    logic [3:0]  order_q [$];
    result_t     expected_q [$];

    function automatic logic is_earlier(logic [31:0] a, logic [31:0] b);
        logic [31:0] d;
        d = a - b;
        return d[31];
    endfunction

    task automatic drop_slot(logic [3:0] slot);
        for (int i = 0; i < order_q.size(); i++)
        begin
            if (order_q[i] == slot)
            begin
                order_q.delete(i);
                break;
            end
        end
        queued_q[slot] = 1'b0;
    endtask

    task automatic predict_item(opcode_t op, logic [3:0] slot, logic [31:0] tval);
        logic    refused;
        int      pos;
        result_t r;
        refused = 1'b0;
        if (op == OP_TICK)
            now_q = now_q + 32'd1;
        else if (op == OP_STOP)
        begin
            if (queued_q[slot])
                drop_slot(slot);
        end
        else if (queued_q[slot])
            refused = 1'b1;
        else
        begin
            expiry_q[slot] = (op == OP_ABS) ? tval : now_q + tval;
            pos = order_q.size();
            for (int i = 0; i < order_q.size(); i++)
            begin
                if (is_earlier(expiry_q[slot], expiry_q[order_q[i]]))
                begin
                    pos = i;
                    break;
                end
            end
            order_q.insert(pos, slot);
            queued_q[slot] = 1'b1;
        end
        r = '{KIND_ACK, 4'd0, refused ? STATUS_BUSY : STATUS_OK, now_q, 1'b1};
        expected_q.push_back(r);
        while (order_q.size() > 0 && !is_earlier(now_q, expiry_q[order_q[0]]))
        begin
            expected_q[expected_q.size() - 1].last = 1'b0;
            r = '{KIND_FIRED, order_q[0], STATUS_OK, now_q, 1'b1};
            expected_q.push_back(r);
            drop_slot(order_q[0]);
        end
        if (refused)
            refused_seen++;
    endtask

    task automatic report(string what, logic [39:0] got, logic [39:0] want);
        $display("mismatch at %0t: %s got %0h expected %0h", $time, what, got, want);
        errors++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        result_t w;
        if (!rst_n)
        begin
            now_q = '0;
            for (int i = 0; i < 16; i++)
                queued_q[i] = 1'b0;
            order_q.delete();
            expected_q.delete();
            errors = 0;
            pending = 0;
            fired_seen = 0;
            refused_seen = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (expected_q.size() == 0)
                    report("unexpected item", m_tdata, '0);
                else
                begin
                    w = expected_q.pop_front();
                    if (m_tuser != w.kind)
                        report("kind", m_tuser, w.kind);
                    if (m_tdata[3:0] != w.fired_slot)
                        report("fired_slot", m_tdata[3:0], w.fired_slot);
                    if (m_tdata[4] != w.status)
                        report("status", m_tdata[4], w.status);
                    if (m_tdata[36:5] != w.current_time)
                        report("current_time", m_tdata[36:5], w.current_time);
                    if (m_tlast != w.last)
                        report("last", m_tlast, w.last);
                    if (w.kind == KIND_FIRED)
                        fired_seen++;
                end
            end
            if (s_tvalid && s_tready)
                predict_item(opcode_t'(s_tuser), s_tdata[3:0], s_tdata[35:4]);
            pending = expected_q.size();
        end
    end
endmodule

FILE: test/tb.sv
// Testbench top for the sorted timer expiry queue: drives directed and random
// items with bursty idling and a stalling receiver, and prints the verdict.
// Depends on stq_pkg, stq_checker and sorted_timer_expiry_queue_core.
`timescale 1ns / 1ps

module tb;
    import stq_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [39:0] s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;
    logic        m_tuser;
    logic        m_tlast;
    int          errors;
    int          pending;
    int          fired_seen;
    int          refused_seen;
    int          cycles;
    int          sent;
    int          stall_mode;

    sorted_timer_expiry_queue_core dut (.*);
    stq_checker checker_i (.*);

    initial clk = 1'b0;
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > 2000000)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("simulation failed");
            $finish;
        end
    end

    // The receiver alternates between stretches of no stalls and random stalls.
    always @(posedge clk)
    begin
        if ($urandom_range(0, 63) == 0)
            stall_mode <= $urandom_range(0, 2);
        case (stall_mode)
            0: m_tready <= 1'b1;
            1: m_tready <= ($urandom_range(0, 3) != 0);
            default: m_tready <= ($urandom_range(0, 3) == 0);
        endcase
    end

    task automatic send_item(opcode_t op, logic [3:0] slot, logic [31:0] tval);
        s_tvalid <= 1'b1;
        s_tuser <= op;
        s_tdata <= {4'd0, tval, slot};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        sent++;
    endtask

    task automatic pause_gap();
        int gap;
        gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    function automatic logic [31:0] near_value();
        case ($urandom_range(0, 4))
            0: return $urandom_range(0, 6);
            1: return 32'hFFFF_FFFF - $urandom_range(0, 3);
            2: return 32'h8000_0000 + $urandom_range(0, 2) - 1;
            3: return $urandom;
            default: return $urandom_range(0, 30);
        endcase
    endfunction

    initial
    begin
        int burst;
        opcode_t op;
        cycles = 0;
        sent = 0;
        stall_mode = 0;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = OP_TICK;
        m_tready = 1'b1;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_item(OP_ABS, 4'd0, 32'd3);
        send_item(OP_ABS, 4'd15, 32'd3);
        send_item(OP_REL, 4'd5, 32'd3);
        send_item(OP_ABS, 4'd5, 32'd9);
        send_item(OP_STOP, 4'd7, 32'hFFFF_FFFF);
        send_item(OP_REL, 4'd9, 32'hFFFF_FFFF);
        send_item(OP_ABS, 4'd10, 32'h8000_0000);
        send_item(OP_TICK, 4'd3, 32'h1234_5678);
        send_item(OP_TICK, 4'd0, 32'd0);
        send_item(OP_STOP, 4'd0, 32'd0);
        send_item(OP_TICK, 4'd0, 32'd0);
        send_item(OP_ABS, 4'd1, 32'd0);
        send_item(OP_REL, 4'd2, 32'd0);
        for (int i = 0; i < 16; i++)
            send_item(OP_REL, i[3:0], 32'd2);
        send_item(OP_TICK, 4'd0, 32'd0);
        send_item(OP_TICK, 4'd0, 32'd0);

        while (sent < 270)
        begin
            burst = $urandom_range(1, 16);
            for (int i = 0; i < burst; i++)
            begin
                op = opcode_t'($urandom_range(0, 3));
                send_item(op, 4'($urandom_range(0, 15)), near_value());
            end
            pause_gap();
        end
        s_tvalid <= 1'b0;

        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
        $display("sent %0d items; %0d timers fired, %0d starts refused",
                 sent, fired_seen, refused_seen);
        if (errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end
endmodule

FILE: filelist.f
hw/rtl/stq_pkg.sv
hw/rtl/stq_ram.sv
hw/rtl/stq_ctrl.sv
hw/rtl/sorted_timer_expiry_queue_core.sv
test/stq_checker.sv
test/tb.sv
